// ----- rtl/core/bmp_24bit_stream_writer_core_defines.svh -----
// Assertion macros used by the stream writer back end.
`ifndef BMP_24BIT_STREAM_WRITER_CORE_DEFINES_SVH
`define BMP_24BIT_STREAM_WRITER_CORE_DEFINES_SVH

`ifndef SYNTH
`define BMPW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BMPW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BMPW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BMPW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/bmpw_pkg.sv -----
// Types and constants shared by the BMP stream writer modules.
`default_nettype none
package bmpw_pkg;

   localparam int DIM_W = 13;
   localparam int COLOR_W = 24;
   localparam int BYTE_W = 8;
   localparam int PAD_W = 2;
   localparam int ROW_BYTES_W = 15;
   localparam int IMG_W = 28;
   localparam int FILE_W = 29;
   localparam int STEP_W = 6;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STEP_W-1:0] HDR_BYTES = 6'd54;
   localparam logic [STEP_W-1:0] STEP_BLUE = 6'd54;
   localparam logic [STEP_W-1:0] STEP_GREEN = 6'd55;
   localparam logic [STEP_W-1:0] STEP_RED = 6'd56;

   localparam logic [31:0] PIXEL_OFFSET = 32'd54;
   localparam logic [31:0] INFO_SIZE = 32'h28;
   localparam logic [31:0] PLANES = 32'h1;
   localparam logic [31:0] BIT_COUNT = 32'h18;

   localparam logic [ROW_BYTES_W-1:0] RESET_ROW_BYTES = 15'd4;
   localparam logic [IMG_W-1:0] RESET_IMG = 28'd4;
   localparam logic [FILE_W-1:0] RESET_FILE = 29'd58;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               header;
      logic [PAD_W-1:0]   pad;
      logic               frame_end;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [IMG_W-1:0]  img_size;
      logic [FILE_W-1:0] file_size;
   } geom_type;

   function automatic logic [BYTE_W-1:0] header_byte(input logic [STEP_W-1:0] idx,
                                                     input geom_type g);
      logic [31:0] v;
      logic [STEP_W-1:0] base;
      logic [1:0] off;
      logic [31:0] shifted;
      v = 32'd0;
      base = idx;
      if (idx == 6'd0) begin
         v = 32'h42;
      end else if (idx == 6'd1) begin
         v = 32'h4D;
      end else if (idx >= 6'd2 && idx <= 6'd5) begin
         v = 32'(g.file_size);
         base = 6'd2;
      end else if (idx >= 6'd10 && idx <= 6'd13) begin
         v = PIXEL_OFFSET;
         base = 6'd10;
      end else if (idx >= 6'd14 && idx <= 6'd17) begin
         v = INFO_SIZE;
         base = 6'd14;
      end else if (idx >= 6'd18 && idx <= 6'd21) begin
         v = 32'(g.width);
         base = 6'd18;
      end else if (idx >= 6'd22 && idx <= 6'd25) begin
         v = 32'(g.height);
         base = 6'd22;
      end else if (idx >= 6'd26 && idx <= 6'd27) begin
         v = PLANES;
         base = 6'd26;
      end else if (idx >= 6'd28 && idx <= 6'd29) begin
         v = BIT_COUNT;
         base = 6'd28;
      end else if (idx >= 6'd34 && idx <= 6'd37) begin
         v = 32'(g.img_size);
         base = 6'd34;
      end
      off = 2'(idx - base);
      shifted = v >> {off, 3'b000};
      return shifted[BYTE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bmpw_front.sv -----
// Front end: configuration registers, frame position tracking, word classification and image sizes.
`default_nettype none
module bmpw_front import bmpw_pkg::*; #(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_wdata,
   input  wire logic                   push,
   input  wire logic                   full,
   input  wire logic [COLOR_W-1:0]     pixel_color,
   output cmd_type                     cmd,
   output geom_type                    geom
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic header_sent_ff, header_sent_in;
   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [IMG_W-1:0] img_ff, img_in;
   logic [FILE_W-1:0] file_ff, file_in;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [ROW_BYTES_W-1:0] w3;
   logic row_end, frame_end, accept;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign accept = push && !full;
   assign w_eff = clamp_dim(width_ff);
   assign h_eff = clamp_dim(height_ff);
   assign w3 = ROW_BYTES_W'(w_eff) * ROW_BYTES_W'(3) + ROW_BYTES_W'(3);
   assign row_end = ({1'b0, col_ff} + (DIM_W+1)'(1)) >= {1'b0, w_eff};
   assign frame_end = row_end && (({1'b0, row_ff} + (DIM_W+1)'(1)) >= {1'b0, h_eff});

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      col_in = col_ff;
      row_in = row_ff;
      header_sent_in = header_sent_ff;
      if (accept) begin
         header_sent_in = !frame_end;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + DIM_W'(1);
         end else begin
            col_in = col_ff + DIM_W'(1);
         end
      end
      row_bytes_in = {w3[ROW_BYTES_W-1:2], 2'b00};
      img_in = IMG_W'(row_bytes_ff) * IMG_W'(h_eff);
      file_in = FILE_W'(img_ff) + FILE_W'(PIXEL_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         col_ff <= '0;
         row_ff <= '0;
         header_sent_ff <= 1'b0;
         row_bytes_ff <= RESET_ROW_BYTES;
         img_ff <= RESET_IMG;
         file_ff <= RESET_FILE;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         header_sent_ff <= header_sent_in;
         row_bytes_ff <= row_bytes_in;
         img_ff <= img_in;
         file_ff <= file_in;
      end
   end

   always_comb begin
      cmd.color = pixel_color;
      cmd.header = !header_sent_ff;
      cmd.pad = row_end ? w_eff[PAD_W-1:0] : '0;
      cmd.frame_end = frame_end;
      geom.width = w_eff;
      geom.height = h_eff;
      geom.img_size = img_ff;
      geom.file_size = file_ff;
   end

endmodule
`default_nettype wire

// ----- rtl/core/bmpw_queue.sv -----
// Short command queue between the front end and the byte sequencer.
`default_nettype none
module bmpw_queue import bmpw_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/bmpw_back.sv -----
// Back end: byte sequencer for header, pixel and padding words with an output register.
`default_nettype none
`include "bmp_24bit_stream_writer_core_defines.svh"
module bmpw_back import bmpw_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   input  wire cmd_type           cmd,
   output logic                   cmd_pop,
   input  wire geom_type          geom,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [BYTE_W-1:0]      rsp_byte_value,
   output logic                   rsp_last_of_run,
   output logic                   rsp_end_of_image
);

   logic started_ff, started_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic eoi_ff, eoi_in;
   logic [STEP_W-1:0] cur_step;
   logic [STEP_W-1:0] final_step;
   logic advance, is_last;

   assign cur_step = started_ff ? step_ff : (cmd.header ? '0 : STEP_BLUE);
   assign final_step = STEP_RED + STEP_W'(cmd.pad);
   assign is_last = cur_step == final_step;
   assign advance = !cmd_empty && (!out_valid_ff || rsp_pop);
   assign cmd_pop = advance && is_last;

   always_comb begin
      started_in = started_ff;
      step_in = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      byte_in = byte_ff;
      last_in = last_ff;
      eoi_in = eoi_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         last_in = is_last;
         eoi_in = is_last && cmd.frame_end;
         started_in = !is_last;
         step_in = cur_step + STEP_W'(1);
         if (cur_step < HDR_BYTES) begin
            byte_in = header_byte(cur_step, geom);
         end else if (cur_step == STEP_BLUE) begin
            byte_in = cmd.color[7:0];
         end else if (cur_step == STEP_GREEN) begin
            byte_in = cmd.color[15:8];
         end else if (cur_step == STEP_RED) begin
            byte_in = cmd.color[23:16];
         end else begin
            byte_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      eoi_ff <= eoi_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_end_of_image = eoi_ff;

   `BMPW_ASSERT_IMP(a_eoi_is_last, clock, reset, out_valid_ff && eoi_ff, last_ff, "end of image without last of run")
   `BMPW_ASSERT_IMP(a_step_range, clock, reset, started_ff, step_ff <= STEP_RED + STEP_W'(3), "sequencer step out of range")
   `BMPW_ASSERT_IMP(a_header_only_first, clock, reset, started_ff && !cmd_empty && step_ff < HDR_BYTES, cmd.header, "header step on a word without header")
   `BMPW_ASSERT_NXT(a_pop_restarts, clock, reset, cmd_pop, !started_ff, "sequencer still busy after word completion")

endmodule
`default_nettype wire

// ----- rtl/core/bmp_24bit_stream_writer_core.sv -----
// Top level of the uncompressed 24-bit BMP stream writer.
// A pixel's first byte goes through the command queue, then the output register, to the result ports.
// Bytes: three per pixel, one per cycle while commands wait and the output register is free or popped.
// A row's last pixel adds up to three padding bytes; a frame's first pixel adds 54 header bytes.
// The command queue holds QUEUE_DEPTH pixels (four by default), so the input keeps accepting while results wait.
// Synchronous active-high reset sets width and height to 1 and restarts at a new frame header.
`default_nettype none
module bmp_24bit_stream_writer_core import bmpw_pkg::*; #(
   parameter int MAX_DIMENSION = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_wdata,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [COLOR_W-1:0]     req_pixel_color,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [BYTE_W-1:0]           rsp_byte_value,
   output logic                        rsp_last_of_run,
   output logic                        rsp_end_of_image
);

   cmd_type  front_cmd;
   cmd_type  head_cmd;
   geom_type geom;
   logic     q_empty;
   logic     q_pop;

   bmpw_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .full       (full),
      .pixel_color(req_pixel_color),
      .cmd        (front_cmd),
      .geom       (geom)
   );

   bmpw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(front_cmd),
      .full    (full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head_cmd(head_cmd)
   );

   bmpw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (q_empty),
      .cmd             (head_cmd),
      .cmd_pop         (q_pop),
      .geom            (geom),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_image(rsp_end_of_image)
   );

endmodule
`default_nettype wire
